@@ rtl/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types, codes and helpers for the websocket deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

    // default depth of the queue between parser and output stage
    localparam int QUEUE_DEPTH_DEF = 4;

    // frame header constants
    localparam logic [7:0] FIN_BIT     = 8'h80;
    localparam logic [7:0] OPCODE_MASK = 8'h0F;
    localparam logic [7:0] LEN_MASK    = 8'h7F;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;

    // opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // parse phase
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    // result kind
    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_EMPTY     = 3'd1,
        KIND_CLOSE     = 3'd2,
        KIND_PING      = 3'd3,
        KIND_BAD_FIRST = 3'd4,
        KIND_NOT_CONT  = 3'd5
    } t_kind;

    // one result item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       frame_last;
        logic       message_last;
        logic [1:0] message_type;
    } t_result;

    // error classification of a frame; KIND_DATA means no error
    function automatic t_kind frame_error(input logic [3:0] opcode, input logic first);
        t_kind k;
        k = KIND_DATA;
        if (opcode == OP_CLOSE) begin
            k = KIND_CLOSE;
        end else if (opcode == OP_PING) begin
            k = KIND_PING;
        end else if (first) begin
            if (opcode != OP_TEXT && opcode != OP_BIN) begin
                k = KIND_BAD_FIRST;
            end
        end else if (opcode != OP_CONT) begin
            k = KIND_NOT_CONT;
        end
        return k;
    endfunction

endpackage

@@ rtl/wsd_parser.sv @@
// ----------------------------------------------------------------------------
// wsd_parser
// front part: takes one byte per cycle while the queue has space, walks the
// frame header, unmasks payload and classifies each byte into at most one result item
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_space,
    output logic             o_ready,
    output logic             o_push,
    output wsd_pkg::t_result o_result
);
    import wsd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_ext_left, n_ext_left;
    logic [63:0] r_rem_len, n_rem_len;
    logic [31:0] r_mask_key, n_mask_key;
    logic [1:0]  r_mask_idx, n_mask_idx;
    logic        r_masked, n_masked;
    logic        r_fin, n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_await_first, n_await_first;
    logic [1:0]  r_msg_type, n_msg_type;
    logic        r_halted, n_halted;

    logic        accept;
    logic        len_done;
    logic        hdr_done;
    logic        end_frame;
    logic        end_empty;
    logic        end_byte;
    logic [6:0]  len7;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    t_kind       err;
    logic [1:0]  cur_type;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;
    assign err     = frame_error(r_opcode, r_await_first);
    assign cur_type = r_await_first ? r_opcode[1:0] : r_msg_type;
    assign len7    = i_byte[6:0] & LEN_MASK[6:0];

    // key byte for the current payload position, most significant first
    always_comb begin
        case (r_mask_idx)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end
    assign plain = i_byte ^ key_byte;

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_ext_left    = r_ext_left;
        n_rem_len     = r_rem_len;
        n_mask_key    = r_mask_key;
        n_mask_idx    = r_mask_idx;
        n_masked      = r_masked;
        n_fin         = r_fin;
        n_opcode      = r_opcode;
        n_await_first = r_await_first;
        n_msg_type    = r_msg_type;
        n_halted      = r_halted;
        len_done      = 1'b0;
        hdr_done      = 1'b0;
        end_frame     = 1'b0;
        end_empty     = 1'b0;
        end_byte      = 1'b0;

        if (accept && !r_halted) begin
            case (r_phase)
                PH_HDR1: begin
                    n_masked   = i_byte[7];
                    n_mask_key = '0;
                    n_mask_idx = '0;
                    n_rem_len  = '0;
                    if (len7 == LEN_EXT16) begin
                        n_ext_left = 4'd2;
                        n_phase    = PH_EXT;
                    end else if (len7 == LEN_EXT64) begin
                        n_ext_left = 4'd8;
                        n_phase    = PH_EXT;
                    end else begin
                        n_rem_len = {57'd0, len7};
                        len_done  = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_rem_len  = {r_rem_len[55:0], i_byte};
                    n_ext_left = r_ext_left - 4'd1;
                    len_done   = (n_ext_left == 4'd0);
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_byte};
                    n_ext_left = r_ext_left - 4'd1;
                    hdr_done   = (n_ext_left == 4'd0);
                end
                PH_DATA: begin
                    n_mask_idx = r_mask_idx + 2'd1;
                    n_rem_len  = r_rem_len - 64'd1;
                    if (n_rem_len == 64'd0) begin
                        end_frame = 1'b1;
                        end_byte  = 1'b1;
                    end
                end
                default: begin
                    n_fin    = |(i_byte & FIN_BIT);
                    n_opcode = i_byte[3:0] & OPCODE_MASK[3:0];
                    n_phase  = PH_HDR1;
                end
            endcase

            // length known: mask key next, or header complete
            if (len_done) begin
                if (n_masked) begin
                    n_ext_left = 4'd4;
                    n_phase    = PH_MASK;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            // header complete: payload, or an empty frame ends here
            if (hdr_done) begin
                if (n_rem_len == 64'd0) begin
                    end_frame = 1'b1;
                    end_empty = 1'b1;
                end else begin
                    n_phase = PH_DATA;
                end
            end

            // frame end: halt on error, otherwise track the message
            if (end_frame) begin
                n_phase = PH_HDR0;
                if (err != KIND_DATA) begin
                    n_halted = 1'b1;
                end else begin
                    if (r_await_first) begin
                        n_msg_type    = r_opcode[1:0];
                        n_await_first = 1'b0;
                    end
                    if (r_fin) begin
                        n_await_first = 1'b1;
                    end
                end
            end
        end
    end

    // result item: error or last item at frame end, else a payload byte
    always_comb begin
        o_push   = 1'b0;
        o_result = '{kind: KIND_DATA, data: 8'h00, frame_last: 1'b0,
                     message_last: 1'b0, message_type: 2'd0};
        if (end_frame) begin
            if (err != KIND_DATA) begin
                o_push   = 1'b1;
                o_result = '{kind: err, data: 8'h00, frame_last: 1'b1,
                             message_last: 1'b1, message_type: r_msg_type};
            end else if (end_byte) begin
                o_push   = 1'b1;
                o_result = '{kind: KIND_DATA, data: plain, frame_last: 1'b1,
                             message_last: r_fin, message_type: cur_type};
            end else if (end_empty && r_fin) begin
                o_push   = 1'b1;
                o_result = '{kind: KIND_EMPTY, data: 8'h00, frame_last: 1'b1,
                             message_last: 1'b1, message_type: cur_type};
            end
        end else if (accept && !r_halted && r_phase == PH_DATA && err == KIND_DATA) begin
            o_push   = 1'b1;
            o_result = '{kind: KIND_DATA, data: plain, frame_last: 1'b0,
                         message_last: 1'b0, message_type: cur_type};
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR0;
            r_ext_left    <= '0;
            r_rem_len     <= '0;
            r_mask_key    <= '0;
            r_mask_idx    <= '0;
            r_masked      <= 1'b0;
            r_fin         <= 1'b0;
            r_opcode      <= '0;
            r_await_first <= 1'b1;
            r_msg_type    <= OP_TEXT[1:0];
            r_halted      <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_ext_left    <= n_ext_left;
            r_rem_len     <= n_rem_len;
            r_mask_key    <= n_mask_key;
            r_mask_idx    <= n_mask_idx;
            r_masked      <= n_masked;
            r_fin         <= n_fin;
            r_opcode      <= n_opcode;
            r_await_first <= n_await_first;
            r_msg_type    <= n_msg_type;
            r_halted      <= n_halted;
        end
    end

    // once halted, the parser stays halted until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("parser left halted state");

    // an error item always halts the parser
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.kind != KIND_DATA && o_result.kind != KIND_EMPTY) |=> r_halted)
        else $error("error item without halt");

    // counter of extension or key bytes is live in those phases
    a_ext_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXT || r_phase == PH_MASK) |-> (r_ext_left != 4'd0))
        else $error("extension byte counter empty in header phase");

    // nothing is produced while halted
    a_no_push_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_push)
        else $error("item produced while halted");

endmodule

@@ rtl/wsd_queue.sv @@
// ----------------------------------------------------------------------------
// wsd_queue
// short first-in first-out queue of result items between parser and output
// ----------------------------------------------------------------------------
module wsd_queue #(
    parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsd_pkg::t_result i_item,
    input  logic             i_pop,
    output logic             o_space,
    output logic             o_avail,
    output wsd_pkg::t_result o_item
);
    import wsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_space = (r_count != CW'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_avail;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // pushes are never offered into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("push into full queue");

    // fill count stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ rtl/wsd_out.sv @@
// ----------------------------------------------------------------------------
// wsd_out
// back part: output register that draws items from the queue and presents
// them on the master stream
// ----------------------------------------------------------------------------
module wsd_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  wsd_pkg::t_result i_item,
    output logic             o_pop,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,  // [7:0] data
    output logic             o_m_axis_tlast,  // frame_last
    output logic [7:0]       o_m_axis_tuser   // [2:0] kind, [3] message_last,
                                              // [5:4] message_type, [7:6] zero
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_item;

    // load when the register is empty or its item is being taken
    assign o_pop = i_avail && (!r_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    // stream packing
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_item.data;
    assign o_m_axis_tlast  = r_item.frame_last;
    assign o_m_axis_tuser  = {2'b00, r_item.message_type, r_item.message_last, r_item.kind};

endmodule

@@ rtl/websocket_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// websocket_deframer_unit
// receive-side frame parser: one byte per item in, unmasked payload bytes
// and end-of-frame / error reports out
// ----------------------------------------------------------------------------
// path: each result passes the queue and then the output register
// throughput: one byte per cycle while the queue has space, limited by the
// single-byte parser state update; the queue of QUEUE_DEPTH items absorbs output stalls
// reset: synchronous, active low; parser returns to header, queue and output
// register empty, halt after an error cleared
module websocket_deframer_unit #(
    parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] data
    output logic       o_m_axis_tlast,   // frame_last
    output logic [7:0] o_m_axis_tuser    // [2:0] kind, [3] message_last,
                                         // [5:4] message_type, [7:6] zero
);
    import wsd_pkg::*;

    logic    q_space;
    logic    q_avail;
    logic    q_pop;
    logic    p_push;
    t_result p_result;
    t_result q_item;

    // front: parser
    wsd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_byte   (i_s_axis_tdata),
        .i_space  (q_space),
        .o_ready  (o_s_axis_tready),
        .o_push   (p_push),
        .o_result (p_result)
    );

    // queue between front and back
    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (p_push),
        .i_item  (p_result),
        .i_pop   (q_pop),
        .o_space (q_space),
        .o_avail (q_avail),
        .o_item  (q_item)
    );

    // back: output register
    wsd_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (q_avail),
        .i_item          (q_item),
        .o_pop           (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
